// ===== rtl/csd_pkg.sv =====
// Shared types, widths and defaults for the chi-square distance block.
package csd_pkg;

	localparam int ELEM_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int FIELD_BITS    = 16;
	localparam int SUM_BITS      = 48;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] a_value;
		logic signed [FIELD_BITS-1:0] b_value;
		logic                         last;
	} elem_t;

	typedef struct packed {
		logic [SUM_BITS-1:0] distance;
		logic                saturated;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_ACC
	} csd_state_t;

endpackage

// ===== rtl/csd_square.sv =====
// Bit-serial shift-and-add squarer, one multiplier bit per cycle.
module csd_square #(
	parameter int OP_BITS = csd_pkg::ELEM_BITS_DEF + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [OP_BITS-1:0]     operand,
	output logic                   done,
	output logic [2*OP_BITS-1:0]   product
);

	localparam int CNT_BITS = $clog2(OP_BITS);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [OP_BITS-1:0]   m_q;
	logic [OP_BITS-1:0]   y_q;
	logic [2*OP_BITS-1:0] p_q;
	logic [OP_BITS:0]     part_sum;

	assign part_sum = {1'b0, p_q[2*OP_BITS-1:OP_BITS]} + (y_q[0] ? {1'b0, m_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_BITS'(OP_BITS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_BITS'(OP_BITS - 1)) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q <= operand;
			y_q <= operand;
			p_q <= '0;
		end else if (busy_q) begin
			y_q <= y_q >> 1;
			p_q <= {part_sum, p_q[OP_BITS-1:1]};
		end
	end

	assign done    = done_q;
	assign product = p_q;

endmodule

// ===== rtl/csd_divide.sv =====
// Restoring divider that produces one quotient bit per cycle.
module csd_divide #(
	parameter int OP_BITS   = csd_pkg::ELEM_BITS_DEF + 1,
	parameter int FRAC_BITS = csd_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [2*OP_BITS-1:0]           dividend,
	input  logic [OP_BITS-1:0]             divisor,
	output logic                           done,
	output logic [OP_BITS+FRAC_BITS-1:0]   quotient
);

	localparam int QW       = OP_BITS + FRAC_BITS;
	localparam int CNT_BITS = $clog2(QW);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [OP_BITS-1:0]  s_q;
	logic [OP_BITS-1:0]  r_q;
	logic [QW-1:0]       nq_q;
	logic [OP_BITS:0]    trial;
	logic [OP_BITS:0]    trial_diff;
	logic                fits;

	assign trial      = {r_q, nq_q[QW-1]};
	assign fits       = trial >= {1'b0, s_q};
	assign trial_diff = trial - {1'b0, s_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_BITS'(QW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_BITS'(QW - 1)) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q  <= divisor;
			r_q  <= dividend[2*OP_BITS-1:OP_BITS];
			nq_q <= QW'(dividend[OP_BITS-1:0]) << FRAC_BITS;
		end else if (busy_q) begin
			r_q  <= fits ? trial_diff[OP_BITS-1:0] : trial[OP_BITS-1:0];
			nq_q <= {nq_q[QW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = nq_q;

endmodule

// ===== rtl/chi_square_distance.sv =====
// Top level of the chi-square distance block: sequencing, accumulation and result register.
// Each item is one element pair (a, b); the block adds (a-b)^2 * 2^FRAC_BITS / (|a|+|b|),
// truncated, to a 48-bit sum that saturates at its maximum with a sticky flag, and on the
// item marked last delivers the sum and clears it. A pair whose elements are both zero adds
// nothing. One item is worked on at a time: the bit-serial squarer forms (a-b)^2,
// then the restoring divider divides it by |a|+|b|; a pair of zeros skips both and
// goes straight to accumulation. The result register lets the next item be taken while
// a result waits to be read.
module chi_square_distance #(
	parameter int ELEM_BITS = csd_pkg::ELEM_BITS_DEF,
	parameter int FRAC_BITS = csd_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             elem_valid,
	output logic             elem_ready,
	input  csd_pkg::elem_t   elem,
	output logic             result_valid,
	input  logic             result_ready,
	output csd_pkg::result_t result
);

	localparam int DW = ELEM_BITS + 1;
	localparam int QW = DW + FRAC_BITS;
	localparam int SW = csd_pkg::SUM_BITS;
	localparam int XW = (QW > SW ? QW : SW) + 1;
	localparam logic [SW-1:0] SUM_MAX = '1;

	csd_pkg::csd_state_t state_q;
	csd_pkg::csd_state_t state_d;

	logic [ELEM_BITS-1:0] a_raw;
	logic [ELEM_BITS-1:0] b_raw;
	logic signed [DW-1:0] a_w;
	logic signed [DW-1:0] b_w;
	logic signed [DW-1:0] diff_w;
	logic [DW-1:0]        abs_a;
	logic [DW-1:0]        abs_b;
	logic [DW-1:0]        d_abs;
	logic [DW-1:0]        s_sum;
	logic                 s_nz;

	logic [DW-1:0]        s_q;
	logic                 last_q;
	logic                 skip_q;
	logic [SW-1:0]        acc_q;
	logic                 ovf_q;
	logic                 result_valid_q;
	csd_pkg::result_t     result_q;

	logic                 accept;
	logic                 mul_start;
	logic                 div_start;
	logic                 acc_go;
	logic                 mul_done;
	logic                 div_done;
	logic [2*DW-1:0]      product;
	logic [QW-1:0]        quotient;
	logic [QW-1:0]        term;
	logic [XW-1:0]        sum_full;
	logic                 sat;

	assign a_raw  = ELEM_BITS'($unsigned(elem.a_value));
	assign b_raw  = ELEM_BITS'($unsigned(elem.b_value));
	assign a_w    = DW'(signed'(a_raw));
	assign b_w    = DW'(signed'(b_raw));
	assign diff_w = a_w - b_w;
	assign abs_a  = a_w[DW-1] ? DW'(-a_w) : DW'(a_w);
	assign abs_b  = b_w[DW-1] ? DW'(-b_w) : DW'(b_w);
	assign d_abs  = diff_w[DW-1] ? DW'(-diff_w) : DW'(diff_w);
	assign s_sum  = abs_a + abs_b;
	assign s_nz   = s_sum != '0;

	assign accept = elem_valid && elem_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			csd_pkg::ST_IDLE: begin
				if (elem_valid) begin
					state_d = s_nz ? csd_pkg::ST_MUL : csd_pkg::ST_ACC;
				end
			end
			csd_pkg::ST_MUL: begin
				if (mul_done) begin
					state_d = csd_pkg::ST_DIV;
				end
			end
			csd_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = csd_pkg::ST_ACC;
				end
			end
			csd_pkg::ST_ACC: begin
				if (acc_go) begin
					state_d = csd_pkg::ST_IDLE;
				end
			end
			default: state_d = csd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		elem_ready = 1'b0;
		mul_start  = 1'b0;
		div_start  = 1'b0;
		acc_go     = 1'b0;
		unique case (state_q)
			csd_pkg::ST_IDLE: begin
				elem_ready = 1'b1;
				mul_start  = elem_valid && s_nz;
			end
			csd_pkg::ST_MUL: begin
				div_start = mul_done;
			end
			csd_pkg::ST_DIV: begin
			end
			csd_pkg::ST_ACC: begin
				acc_go = !(last_q && result_valid_q && !result_ready);
			end
			default: begin
			end
		endcase
	end

	csd_square #(
		.OP_BITS(DW)
	) u_square (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.operand (d_abs),
		.done    (mul_done),
		.product (product)
	);

	csd_divide #(
		.OP_BITS   (DW),
		.FRAC_BITS (FRAC_BITS)
	) u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (s_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign term     = skip_q ? '0 : quotient;
	assign sum_full = XW'(acc_q) + XW'(term);
	assign sat      = sum_full > XW'(SUM_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= csd_pkg::ST_IDLE;
			acc_q          <= '0;
			ovf_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc_go && last_q) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (acc_go) begin
				if (last_q) begin
					acc_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					acc_q <= sat ? SUM_MAX : sum_full[SW-1:0];
					ovf_q <= ovf_q | sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_q    <= s_sum;
			last_q <= elem.last;
			skip_q <= !s_nz;
		end
		if (acc_go && last_q) begin
			result_q.distance  <= sat ? SUM_MAX : sum_full[SW-1:0];
			result_q.saturated <= ovf_q | sat;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_done && div_done))
		else $error("Squarer and divider finished in the same cycle.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(acc_go && last_q))
		else $error("Result appeared without a last item being accumulated.");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.saturated |-> result.distance == SUM_MAX)
		else $error("Saturated result does not hold the maximum sum.");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !elem_ready)
		else $error("A new item was offered ready while the previous one was in work.");

endmodule

// ===== tb/chi_square_distance_tb.sv =====
// Self-checking testbench for the chi-square distance block with a built-in sum predictor.
`timescale 1ns / 100ps

module chi_square_distance_tb;

	localparam int FRAC = csd_pkg::FRAC_BITS_DEF;
	localparam logic [csd_pkg::SUM_BITS-1:0] SUM_LIMIT = '1;
	localparam int BIG_PAIRS = 24;
	localparam int RX_HOLD_CYCLES = 500;

	typedef struct {
		csd_pkg::elem_t pair;
		int unsigned    gap;
		bit             drain;
	} stim_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             elem_valid = 1'b0;
	logic             elem_ready;
	csd_pkg::elem_t   elem = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	csd_pkg::result_t result;

	stim_t            pair_queue[$];
	csd_pkg::result_t expected_sums[$];

	logic [csd_pkg::SUM_BITS-1:0] model_sum;
	logic                         model_clamped;

	stim_t       staged;
	bit          have_staged;
	int unsigned tx_wait;
	int unsigned rx_wait;
	int unsigned pairs_sent;
	int unsigned sums_checked;
	int unsigned clamped_sums;
	int unsigned failures;

	chi_square_distance uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.elem_valid   (elem_valid),
		.elem_ready   (elem_ready),
		.elem         (elem),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Truncated (a-b)^2 * 2^FRAC / (|a|+|b|); zero when both elements are zero.
	function automatic logic [63:0] chi_term(csd_pkg::elem_t p);
		longint a;
		longint b;
		logic [63:0] d;
		logic [63:0] s;
		a = longint'($signed(p.a_value));
		b = longint'($signed(p.b_value));
		d = (a > b) ? a - b : b - a;
		s = (a < 0 ? -a : a) + (b < 0 ? -b : b);
		if (s == 0)
			return '0;
		return ((d * d) << FRAC) / s;
	endfunction

	function automatic void accumulate_pair(csd_pkg::elem_t p);
		logic [63:0] term;
		term = chi_term(p);
		if (term > {16'd0, SUM_LIMIT - model_sum}) begin
			model_sum = SUM_LIMIT;
			model_clamped = 1'b1;
		end else begin
			model_sum = model_sum + term[csd_pkg::SUM_BITS-1:0];
		end
		if (p.last) begin
			expected_sums.insert(expected_sums.size(),
				csd_pkg::result_t'{distance: model_sum, saturated: model_clamped});
			model_sum = '0;
			model_clamped = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic send_next;
		if (!arst_n) begin
			elem_valid <= 1'b0;
			elem <= '0;
			have_staged = 0;
			tx_wait = 0;
			model_sum = '0;
			model_clamped = 1'b0;
		end else begin
			send_next = elem_valid;
			if (elem_valid && elem_ready) begin
				accumulate_pair(elem);
				pairs_sent++;
				send_next = 1'b0;
			end
			if (!send_next) begin
				if (!have_staged && pair_queue.size() != 0) begin
					staged = pair_queue.pop_front();
					have_staged = 1;
					tx_wait = staged.gap;
				end
				if (have_staged) begin
					if (tx_wait != 0) begin
						tx_wait--;
					end else if (!staged.drain || expected_sums.size() == 0) begin
						elem <= staged.pair;
						send_next = 1'b1;
						have_staged = 0;
					end
				end
			end
			elem_valid <= send_next;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		logic take_next;
		csd_pkg::result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
			rx_wait = 0;
		end else begin
			take_next = result_ready;
			if (result_valid && result_ready) begin
				sums_checked++;
				if (result.saturated)
					clamped_sums++;
				if (expected_sums.size() == 0) begin
					$error("unexpected result: distance %0d saturated %0b",
						result.distance, result.saturated);
					failures++;
				end else begin
					want = expected_sums.pop_front();
					if (result.distance !== want.distance) begin
						$error("distance: expected %0d, actual %0d",
							want.distance, result.distance);
						failures++;
					end
					if (result.saturated !== want.saturated) begin
						$error("saturated: expected %0b, actual %0b",
							want.saturated, result.saturated);
						failures++;
					end
				end
				take_next = 1'b0;
				if (sums_checked == 30 || sums_checked == 160)
					rx_wait = RX_HOLD_CYCLES;
				else if (sums_checked[6])
					rx_wait = 0;
				else
					rx_wait = $urandom_range(0, 4);
			end
			if (!take_next) begin
				if (rx_wait != 0)
					rx_wait--;
				else
					take_next = 1'b1;
			end
			result_ready <= take_next;
		end
	end

	task automatic add_pair(int a, int b, bit last, int unsigned gap, bit drain);
		stim_t s;
		s.pair = '{a_value: a[15:0], b_value: b[15:0], last: last};
		s.gap = gap;
		s.drain = drain;
		pair_queue.insert(pair_queue.size(), s);
	endtask

	function automatic int random_element();
		int v;
		case ($urandom_range(0, 9)) inside
			[0:3]: v = $signed($urandom_range(0, 65535) - 32768);
			4: v = $urandom_range(0, 1) ? 32767 : -32768;
			5: v = 0;
			6: v = $signed($urandom_range(0, 16)) - 8;
			default: v = $signed($urandom_range(0, 2047)) - 1024;
		endcase
		return v;
	endfunction

	initial begin
		int a;
		int b;
		int n;
		int total;
		int vectors;
		bit calm;

		add_pair(0, 0, 1, 0, 0);
		add_pair(-32768, 32767, 1, 1, 0);
		add_pair(32767, -32768, 1, 0, 0);
		add_pair(-32768, -32768, 1, 2, 0);
		add_pair(32767, 32767, 1, 0, 0);
		add_pair(-1, 1, 1, 0, 0);
		add_pair(1, 0, 1, 3, 0);
		add_pair(0, -32768, 0, 0, 0);
		add_pair(0, 0, 0, 0, 0);
		add_pair(5, 3, 0, 1, 0);
		add_pair(0, 0, 1, 0, 0);
		add_pair(-32768, 0, 0, 0, 0);
		add_pair(0, 32767, 1, 4, 0);
		add_pair(7, -3, 0, 0, 0);
		add_pair(100, 99, 0, 0, 0);
		add_pair(-12345, 6789, 0, 2, 0);
		add_pair(3, 7, 1, 0, 0);
		add_pair(1, -1, 1, 0, 1);

		// Largest terms back to back in one vector to drive the sum high.
		for (int i = 0; i < BIG_PAIRS; i++) begin
			if (i[0])
				add_pair(32767, -32768, i == BIG_PAIRS - 1, 0, i == 0);
			else
				add_pair(-32768, 32767, i == BIG_PAIRS - 1, 0, i == 0);
		end
		add_pair(2, 1, 1, 0, 0);

		total = 0;
		vectors = 0;
		while (total < 1800) begin
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < n; i++) begin
				a = random_element();
				case ($urandom_range(0, 7))
					0: b = a;
					1: b = -a;
					2: b = 0;
					default: b = random_element();
				endcase
				add_pair(a, b, i == n - 1, calm ? 0 : $urandom_range(0, 4),
					i == 0 && vectors % 40 == 0);
			end
			total += n;
			vectors++;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pair_queue.size() != 0 || have_staged || elem_valid)
			@(posedge clk);
		while (expected_sums.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);

		$display("Checked %0d sums over %0d element pairs in %0d random vectors.",
			sums_checked, pairs_sent, vectors);
		$display("%0d sums came back clamped at the maximum.", clamped_sums);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== chi_square_distance.f =====
rtl/csd_pkg.sv
rtl/csd_square.sv
rtl/csd_divide.sv
rtl/chi_square_distance.sv
tb/chi_square_distance_tb.sv
